// ===== design/brsp_pkg.sv =====
// ----------------------------------------------------------------------------
// brsp_pkg
// Shared types and constants for the block record stream parser.
// ----------------------------------------------------------------------------
`default_nettype none
package brsp_pkg;

  localparam int unsigned KeyBytes = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned FifoDepth = 4;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] REG_MASK_KEY    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MASK_ENABLE = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MAGIC       = 2'd2;

  localparam logic [31:0] MAGIC_RESET = 32'hD9B4BEF9;
  localparam logic [7:0]  PFX_16      = 8'hFD;
  localparam logic [7:0]  PFX_BASE    = 8'hFC;
  localparam logic [7:0]  BYTE_ZERO   = 8'h00;
  localparam logic [7:0]  BYTE_ONE    = 8'h01;

  // Error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_MAGIC    = 2'd1;
  localparam logic [1:0] ERR_ZERO_SZ  = 2'd2;
  localparam logic [1:0] ERR_SIZE_MIS = 2'd3;

  // Field codes, also used as the parser phase
  typedef enum logic [4:0] {
    F_MAGIC     = 5'd0,
    F_SIZE      = 5'd1,
    F_HVER      = 5'd2,
    F_HPREV     = 5'd3,
    F_HMERKLE   = 5'd4,
    F_HTIME     = 5'd5,
    F_HBITS     = 5'd6,
    F_HNONCE    = 5'd7,
    F_TXCOUNT   = 5'd8,
    F_TXVER     = 5'd9,
    F_MARKER    = 5'd10,
    F_INCOUNT   = 5'd11,
    F_PREVHASH  = 5'd12,
    F_PREVIDX   = 5'd13,
    F_SCRIPTLEN = 5'd14,
    F_SCRIPTSIG = 5'd15,
    F_SEQ       = 5'd16,
    F_OUTCOUNT  = 5'd17,
    F_VALUE     = 5'd18,
    F_PKLEN     = 5'd19,
    F_PKSCRIPT  = 5'd20,
    F_WCOUNT    = 5'd21,
    F_WLEN      = 5'd22,
    F_WDATA     = 5'd23,
    F_LOCK      = 5'd24
  } field_e;

  typedef struct packed {
    field_e      phase;
    logic [3:0]  fbi;
    logic [63:0] acc;
    logic [1:0]  cw;
    logic [63:0] tx_rem;
    logic [63:0] in_cnt;
    logic [63:0] item_rem;
    logic [63:0] welem_rem;
    logic [63:0] data_rem;
    logic [31:0] bsize;
    logic [31:0] bseen;
    logic        segwit;
    logic        held;
    logic        halted;
  } pst_t;

  typedef struct packed {
    logic [7:0]  plain_byte;
    field_e      code;
    logic [63:0] value;
    logic        fdone;
    logic        txdone;
    logic        bdone;
    logic [1:0]  err;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

// ===== design/block_record_stream_parser.sv =====
// ----------------------------------------------------------------------------
// block_record_stream_parser
// Parses a stream of block file bytes into tagged field results.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel raw_byte_i/raw_valid_i/raw_ready_o carries one file byte per
//   transaction. Output channel out_valid_o/out_ready_i carries one tagged result
//   per transaction; a byte causes zero, one or two results (two only on the
//   byte after a held zero in the marker position).
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_index_i
//   (0 mask key, 1 mask enable, 2 expected magic); write only while idle.
//   Flow: a byte is registered in the input register, then parsed into a
//   four-entry result queue once the queue has room for two results; the
//   output shows the head of the queue.
//   Throughput: one byte per cycle while the parse step runs, which is
//   whenever the queue has room for two results.
//   Stall: when the receiver holds off, parsing pauses once the queue holds
//   three results and raw_ready_o drops while a byte waits; nothing is lost.
//   Reset: parser returns to expecting magic, registers take their reset
//   values, the queue empties. After an error the parser drops all bytes
//   until reset, while the mask position keeps advancing.
// ----------------------------------------------------------------------------
`default_nettype none
module block_record_stream_parser (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [brsp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [brsp_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  wire logic [7:0]                      raw_byte_i,
  input  wire logic                            raw_valid_i,
  output      logic                            raw_ready_o,
  output      logic [7:0]                      plain_byte_o,
  output      logic [4:0]                      field_code_o,
  output      logic [63:0]                     field_value_o,
  output      logic                            field_done_o,
  output      logic                            tx_done_o,
  output      logic                            block_done_o,
  output      logic [1:0]                      error_code_o,
  output      logic                            last_o,
  output      logic                            out_valid_o,
  input  wire logic                            out_ready_i
);
  import brsp_pkg::*;

  logic [63:0] mask_key_q;
  logic        mask_en_q;
  logic [31:0] magic_q;
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        fire, room2;
  logic [1:0]  nres;
  res_t        res0, res1, head;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_key_q <= '0;
      mask_en_q  <= 1'b0;
      magic_q    <= MAGIC_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MASK_KEY:    mask_key_q <= cfg_wdata_i;
        REG_MASK_ENABLE: mask_en_q  <= cfg_wdata_i[0];
        REG_MAGIC:       magic_q    <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  // Input register: parse when the queue can take two results
  assign fire        = in_valid_q && room2;
  assign raw_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (raw_ready_o) begin
      in_valid_q <= raw_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (raw_ready_o && raw_valid_i) in_byte_q <= raw_byte_i;
  end

  brsp_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .byte_i     (in_byte_q),
    .mask_key_i (mask_key_q),
    .mask_en_i  (mask_en_q),
    .magic_i    (magic_q),
    .nres_o     (nres),
    .res0_o     (res0),
    .res1_o     (res1)
  );

  brsp_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .nwr_i   (fire ? nres : 2'd0),
    .wr0_i   (res0),
    .wr1_i   (res1),
    .room2_o (room2),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .head_o  (head)
  );

  assign plain_byte_o  = head.plain_byte;
  assign field_code_o  = head.code;
  assign field_value_o = head.value;
  assign field_done_o  = head.fdone;
  assign tx_done_o     = head.txdone;
  assign block_done_o  = head.bdone;
  assign error_code_o  = head.err;
  assign last_o        = head.last;

endmodule
`default_nettype wire

// ===== design/brsp_core.sv =====
// ----------------------------------------------------------------------------
// brsp_core
// Unmasking and field walk for one byte per cycle while fire_i is high; holds the parser state.
// ----------------------------------------------------------------------------
`default_nettype none
module brsp_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 fire_i,
  input  wire logic [7:0]           byte_i,
  input  wire logic [63:0]          mask_key_i,
  input  wire logic                 mask_en_i,
  input  wire logic [31:0]          magic_i,
  output      logic [1:0]           nres_o,
  output      brsp_pkg::res_t       res0_o,
  output      brsp_pkg::res_t       res1_o
);
  import brsp_pkg::*;

  pst_t       st_q, st_d;
  logic [2:0] pos_q;

  function automatic res_t mk(logic [7:0] b, field_e c, logic [63:0] v, logic fd,
                              logic txd, logic bd, logic [1:0] e, logic l);
    res_t r;
    r.plain_byte = b; r.code = c; r.value = v; r.fdone = fd;
    r.txdone = txd; r.bdone = bd; r.err = e; r.last = l;
    return r;
  endfunction

  // Place one byte into its lane of the accumulator
  function automatic logic [63:0] put_lane(logic [63:0] a, logic [7:0] b, logic [2:0] idx);
    logic [63:0] o;
    o = a;
    for (int i = 0; i < 8; i++) begin
      if (idx == 3'(i)) o[8*i +: 8] = a[8*i +: 8] | b;
    end
    return o;
  endfunction

  // Parse one byte in the current phase
  function automatic void run_byte(inout pst_t s, input logic [7:0] b,
                                   input logic [31:0] magic, output res_t r);
    logic [63:0] val;
    logic        done;
    logic        txd, bd;
    logic [1:0]  err;
    field_e      code;
    val = '0; done = 1'b0; txd = 1'b0; bd = 1'b0; err = ERR_NONE;
    if (s.phase > F_LOCK || s.phase == F_MARKER) s.phase = F_MAGIC;
    code = s.phase;
    case (code)
      F_HPREV, F_HMERKLE, F_PREVHASH, F_SCRIPTSIG, F_PKSCRIPT, F_WDATA: begin
        if (s.data_rem != '0) s.data_rem = s.data_rem - 64'd1;
        done = (s.data_rem == '0);
      end
      F_TXCOUNT, F_INCOUNT, F_SCRIPTLEN, F_OUTCOUNT, F_PKLEN, F_WCOUNT, F_WLEN: begin
        if (s.fbi == 4'd0) begin
          if (b < PFX_16) begin
            val = {56'd0, b};
            done = 1'b1;
          end else begin
            s.cw = 2'(b - PFX_BASE);
            s.acc = '0;
            s.fbi = 4'd1;
          end
        end else begin
          s.acc = put_lane(s.acc, b, 3'(s.fbi - 4'd1));
          s.fbi = s.fbi + 4'd1;
          val = s.acc;
          done = ((s.fbi - 4'd1) >= 4'(4'd1 << s.cw));
        end
      end
      F_VALUE: begin
        s.acc = put_lane(s.acc, b, s.fbi[2:0]);
        s.fbi = s.fbi + 4'd1;
        val = s.acc;
        done = (s.fbi >= 4'd8);
      end
      default: begin
        s.acc = put_lane(s.acc, b, s.fbi[2:0]);
        s.fbi = s.fbi + 4'd1;
        val = s.acc;
        done = (s.fbi >= 4'd4);
      end
    endcase

    // Advance to the next field once this one completes
    if (done) begin
      s.fbi = '0; s.acc = '0; s.cw = '0;
      case (code)
        F_MAGIC: begin
          if (val[31:0] != magic) err = ERR_MAGIC;
          else s.phase = F_SIZE;
        end
        F_SIZE: begin
          if (val[31:0] == '0) err = ERR_ZERO_SZ;
          else begin
            s.bsize = val[31:0]; s.bseen = '0; s.phase = F_HVER;
          end
        end
        F_HVER:    begin s.data_rem = 64'd32; s.phase = F_HPREV; end
        F_HPREV:   begin s.data_rem = 64'd32; s.phase = F_HMERKLE; end
        F_HMERKLE: s.phase = F_HTIME;
        F_HTIME:   s.phase = F_HBITS;
        F_HBITS:   s.phase = F_HNONCE;
        F_HNONCE:  s.phase = F_TXCOUNT;
        F_TXCOUNT: begin
          s.tx_rem = val;
          if (val == '0) begin
            s.phase = F_MAGIC;
            err = (s.bseen == s.bsize) ? ERR_NONE : ERR_SIZE_MIS;
            bd = (err == ERR_NONE);
          end else s.phase = F_TXVER;
        end
        F_TXVER: begin s.segwit = 1'b0; s.held = 1'b0; s.phase = F_MARKER; end
        F_INCOUNT: begin
          s.in_cnt = val; s.item_rem = val;
          if (val == '0) s.phase = F_OUTCOUNT;
          else begin s.data_rem = 64'd32; s.phase = F_PREVHASH; end
        end
        F_PREVHASH: s.phase = F_PREVIDX;
        F_PREVIDX:  s.phase = F_SCRIPTLEN;
        F_SCRIPTLEN: begin
          if (val == '0) s.phase = F_SEQ;
          else begin s.data_rem = val; s.phase = F_SCRIPTSIG; end
        end
        F_SCRIPTSIG: s.phase = F_SEQ;
        F_SEQ: begin
          s.item_rem = s.item_rem - 64'd1;
          if (s.item_rem != '0) begin s.data_rem = 64'd32; s.phase = F_PREVHASH; end
          else s.phase = F_OUTCOUNT;
        end
        F_VALUE: s.phase = F_PKLEN;
        F_WDATA, F_WLEN, F_WCOUNT, F_OUTCOUNT, F_PKLEN, F_PKSCRIPT: begin
          // Outputs and witness chain share the after-item walk
          logic out_end, elem_end, wit_end;
          out_end = 1'b0; elem_end = 1'b0; wit_end = 1'b0;
          case (code)
            F_OUTCOUNT: begin
              s.item_rem = val;
              if (val == '0) out_end = 1'b1;
              else s.phase = F_VALUE;
            end
            F_PKLEN, F_PKSCRIPT: begin
              if (code == F_PKLEN && val != '0) begin
                s.data_rem = val; s.phase = F_PKSCRIPT;
              end else begin
                s.item_rem = s.item_rem - 64'd1;
                if (s.item_rem != '0) s.phase = F_VALUE;
                else out_end = 1'b1;
              end
            end
            F_WCOUNT: begin
              s.welem_rem = val;
              if (val == '0) wit_end = 1'b1;
              else s.phase = F_WLEN;
            end
            default: begin
              if (code == F_WLEN && val != '0) begin
                s.data_rem = val; s.phase = F_WDATA;
              end else elem_end = 1'b1;
            end
          endcase
          if (elem_end) begin
            s.welem_rem = s.welem_rem - 64'd1;
            if (s.welem_rem != '0) s.phase = F_WLEN;
            else wit_end = 1'b1;
          end
          if (wit_end) begin
            s.item_rem = s.item_rem - 64'd1;
            s.phase = (s.item_rem != '0) ? F_WCOUNT : F_LOCK;
          end
          if (out_end) begin
            if (s.segwit && s.in_cnt != '0) begin
              s.item_rem = s.in_cnt; s.phase = F_WCOUNT;
            end else s.phase = F_LOCK;
          end
        end
        default: begin
          txd = 1'b1;
          s.tx_rem = s.tx_rem - 64'd1;
          if (s.tx_rem != '0) s.phase = F_TXVER;
          else begin
            s.phase = F_MAGIC;
            err = (s.bseen == s.bsize) ? ERR_NONE : ERR_SIZE_MIS;
            bd = (err == ERR_NONE);
          end
        end
      endcase
      if (err != ERR_NONE) s.halted = 1'b1;
    end
    r = mk(b, code, val, done, txd, bd, err, 1'b0);
  endfunction

  // Step: unmask, count block bytes, resolve the held zero, parse
  always_comb begin
    logic [7:0] b;
    res_t       r;
    st_d   = st_q;
    nres_o = 2'd0;
    res0_o = '0;
    res1_o = '0;
    r      = '0;
    b = byte_i;
    if (mask_en_i) b = byte_i ^ mask_key_i[8*pos_q +: 8];
    if (!st_q.halted) begin
      if (st_q.phase >= F_HVER && st_q.phase <= F_LOCK) st_d.bseen = st_q.bseen + 32'd1;
      if (st_q.phase == F_MARKER) begin
        if (!st_q.held) begin
          if (b == BYTE_ZERO) begin
            st_d.held = 1'b1;
          end else begin
            st_d.phase = F_INCOUNT;
            run_byte(st_d, b, magic_i, r);
            r.last = 1'b1;
            res0_o = r;
            nres_o = 2'd1;
          end
        end else begin
          st_d.held = 1'b0;
          if (b == BYTE_ONE) begin
            res0_o = mk(BYTE_ZERO, F_MARKER, '0, 1'b0, 1'b0, 1'b0, ERR_NONE, 1'b0);
            res1_o = mk(BYTE_ONE, F_MARKER, '0, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b1);
            st_d.segwit = 1'b1;
            st_d.phase = F_INCOUNT;
          end else begin
            res0_o = mk(BYTE_ZERO, F_INCOUNT, '0, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
            st_d.in_cnt = '0;
            st_d.item_rem = '0;
            st_d.phase = F_OUTCOUNT;
            run_byte(st_d, b, magic_i, r);
            r.last = 1'b1;
            res1_o = r;
          end
          nres_o = 2'd2;
        end
      end else begin
        run_byte(st_d, b, magic_i, r);
        r.last = 1'b1;
        res0_o = r;
        nres_o = 2'd1;
      end
    end
  end

  // Commit state on each processed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= '0;
      pos_q <= '0;
    end else if (fire_i) begin
      st_q  <= st_d;
      pos_q <= pos_q + 3'd1;
    end
  end

endmodule
`default_nettype wire

// ===== design/brsp_out_fifo.sv =====
// ----------------------------------------------------------------------------
// brsp_out_fifo
// Four-entry result queue; takes zero, one or two results per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module brsp_out_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [1:0]      nwr_i,
  input  wire brsp_pkg::res_t  wr0_i,
  input  wire brsp_pkg::res_t  wr1_i,
  output      logic            room2_o,
  output      logic            valid_o,
  input  wire logic            ready_i,
  output      brsp_pkg::res_t  head_o
);
  import brsp_pkg::*;

  res_t       mem_q [FifoDepth];
  logic [1:0] wptr_q, rptr_q;
  logic [2:0] cnt_q;
  logic       pop;

  assign valid_o = (cnt_q != 3'd0);
  assign pop     = valid_o && ready_i;
  assign head_o  = mem_q[rptr_q];
  assign room2_o = (cnt_q <= 3'd2);

  // Write up to two entries
  always_ff @(posedge clk_i) begin
    if (nwr_i != 2'd0) mem_q[wptr_q] <= wr0_i;
    if (nwr_i == 2'd2) mem_q[wptr_q + 2'd1] <= wr1_i;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + nwr_i;
      if (pop) rptr_q <= rptr_q + 2'd1;
      cnt_q <= cnt_q + {1'b0, nwr_i} - {2'b0, pop};
    end
  end

endmodule
`default_nettype wire

// ===== design/brsp_checker.sv =====
// ----------------------------------------------------------------------------
// brsp_checker
// Port-level checks on the result stream of the parser.
// ----------------------------------------------------------------------------
`default_nettype none
module brsp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic [4:0]  field_code_o,
  input wire logic [63:0] field_value_o,
  input wire logic        field_done_o,
  input wire logic        tx_done_o,
  input wire logic        block_done_o,
  input wire logic [1:0]  error_code_o,
  input wire logic        last_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i
);
  import brsp_pkg::*;

  // Hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(field_value_o)
      && $stable(field_code_o))
    else $error("stalled result changed");

  // Transaction end only on a completed lock time
  a_txd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tx_done_o |-> field_done_o && field_code_o == F_LOCK)
    else $error("tx_done outside lock time");

  // A passed block never carries an error
  a_bd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && block_done_o |-> error_code_o == ERR_NONE && field_done_o)
    else $error("block_done with error");

  // Block end and errors close their byte's results
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (block_done_o || error_code_o != ERR_NONE) |-> last_o)
    else $error("block end not last");

endmodule

bind block_record_stream_parser brsp_checker u_brsp_checker (.*);
`default_nettype wire
